// ===== rtl/lphm_pkg.sv =====
// Package for the linear probe hash map: sizes, codes, state and control types.
`default_nettype none
package lphm_pkg;

  localparam int SLOT_COUNT  = 1024;
  localparam int ENTRY_COUNT = 768;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int SLOT_AW  = $clog2(SLOT_COUNT);
  localparam int ENTRY_AW = $clog2(ENTRY_COUNT);
  localparam int SLOT_W   = 11;
  localparam int CNT_W    = 10;
  localparam int PROBE_W  = SLOT_AW + 1;
  localparam int TYPE_W   = 2;
  localparam int STAT_W   = 2;

  // one more than the smallest key count at which a set reports full: (count+1)*4 >= slots*3
  localparam int LIMIT_KEYS = (SLOT_COUNT * 3 + 3) / 4;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY = '0;
  localparam logic [SLOT_W-1:0] SLOT_TOMB  = '1;

  localparam logic [TYPE_W-1:0] REQ_SET = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_GET = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DEL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_KEY_CHK,
    S_ALLOC,
    S_PLACE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              clr_wr;
    logic              slot_rd;
    logic              ent_rd;
    logic              note_tgt;
    logic              advance;
    logic              stk_rd;
    logic              place;
    logic              upd_val;
    logic              del;
    logic              set_res;
    logic [STAT_W-1:0] res_code;
    logic              res_val;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [TYPE_W-1:0] req_type;
    logic              limit_full;
    logic              probes_done;
    logic              slot_empty;
    logic              slot_skip;
    logic              key_match;
    logic              have_tgt;
    logic              stack_nonempty;
    logic              out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/linear_probe_hash_map_unit.sv =====
// Top level of the linear probe hash map: controller and datapath.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_req_type, in_key, in_home_slot, in_value
//   out     | output    | out_valid, out_stall, out_status, out_value_out, out_live_count
//
// One item at a time. A set refused at the load limit or an unknown type goes from START
// straight to DONE; otherwise slots are probed in turn from the home slot (an empty or
// tombstone slot is read and checked, a live slot also has its entry read and its key
// compared) until the search ends or all slots are probed, and a set that places a new key
// passes through ALLOC and PLACE. in_stall drops as the result is loaded into the output
// register. After reset a clearing pass empties every slot; in_stall holds. A result waits
// there while out_stall is high; the next item is taken meanwhile and held before its result until the register frees.
`default_nettype none
module linear_probe_hash_map_unit
  import lphm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TYPE_W-1:0]     in_req_type,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [SLOT_AW-1:0]    in_home_slot,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STAT_W-1:0]          out_status,
  output logic [VALUE_BITS-1:0]      out_value_out,
  output logic [CNT_W-1:0]           out_live_count
);

  cmd_t  cmd;
  stat_t stat;

  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lphm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_home_slot   (in_home_slot),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_live_count (out_live_count)
  );

endmodule
`default_nettype wire

// ===== rtl/lphm_ctrl.sv =====
// Controller state machine for the linear probe hash map.
`default_nettype none
module lphm_ctrl
  import lphm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.req_type == REQ_SET) begin
          if (stat.limit_full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_FULL;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_PROBE_RD;
          end
        end else if (stat.req_type == REQ_GET || stat.req_type == REQ_DEL) begin
          state_nxt = S_PROBE_RD;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_MISS;
          state_nxt    = S_DONE;
        end
      end
      S_PROBE_RD: begin
        if (stat.probes_done) begin
          if (stat.req_type == REQ_SET && stat.have_tgt) begin
            state_nxt = S_ALLOC;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = (stat.req_type == REQ_SET) ? ST_FULL : ST_MISS;
            state_nxt    = S_DONE;
          end
        end else begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_PROBE_CHK;
        end
      end
      S_PROBE_CHK: begin
        if (stat.slot_empty) begin
          if (stat.req_type == REQ_SET) begin
            cmd.note_tgt = 1'b1;
            state_nxt    = S_ALLOC;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_MISS;
            state_nxt    = S_DONE;
          end
        end else if (stat.slot_skip) begin
          // remember the first tombstone for placement
          cmd.note_tgt = (stat.req_type == REQ_SET);
          cmd.advance  = 1'b1;
          state_nxt    = S_PROBE_RD;
        end else begin
          cmd.ent_rd = 1'b1;
          state_nxt  = S_KEY_CHK;
        end
      end
      S_KEY_CHK: begin
        if (stat.key_match) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          if (stat.req_type == REQ_SET) begin
            cmd.upd_val = 1'b1;
          end else begin
            cmd.res_val = 1'b1;
            cmd.del     = (stat.req_type == REQ_DEL);
          end
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_PROBE_RD;
        end
      end
      S_ALLOC: begin
        cmd.stk_rd = stat.stack_nonempty;
        state_nxt  = S_PLACE;
      end
      S_PLACE: begin
        cmd.place    = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lphm_dp.sv =====
// Datapath for the linear probe hash map: slot, entry and reuse stores plus counters.
`default_nettype none
module lphm_dp
  import lphm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  wire logic [TYPE_W-1:0]     in_req_type,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [SLOT_AW-1:0]    in_home_slot,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STAT_W-1:0]          out_status,
  output logic [VALUE_BITS-1:0]      out_value_out,
  output logic [CNT_W-1:0]           out_live_count
);

  logic [SLOT_W-1:0]     slot_mem [SLOT_COUNT];
  logic [KEY_BITS-1:0]   key_mem  [ENTRY_COUNT];
  logic [VALUE_BITS-1:0] val_mem  [ENTRY_COUNT];
  logic [ENTRY_AW-1:0]   stk_mem  [ENTRY_COUNT];

  logic [TYPE_W-1:0]     type_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [SLOT_AW-1:0]    pos_r;
  logic [PROBE_W-1:0]    probes_r;
  logic [SLOT_AW-1:0]    tgt_r;
  logic                  have_tgt_r;
  logic                  pop_r;
  logic [ENTRY_AW-1:0]   idx_r;
  logic [SLOT_W-1:0]     slot_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [ENTRY_AW-1:0]   stk_q;
  logic [CNT_W-1:0]      depth_r;
  logic [CNT_W-1:0]      fresh_r;
  logic [CNT_W-1:0]      kc_r;
  logic [SLOT_AW-1:0]    clr_r;
  logic [STAT_W-1:0]     res_status_r;
  logic [VALUE_BITS-1:0] res_val_r;
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic [CNT_W-1:0]      out_live_r;

  logic [ENTRY_AW-1:0]   slot_idx;
  logic [ENTRY_AW-1:0]   new_idx;
  logic                  slot_we;
  logic [SLOT_AW-1:0]    slot_wa;
  logic [SLOT_W-1:0]     slot_wd;
  logic                  val_we;
  logic [ENTRY_AW-1:0]   val_wa;
  logic                  stk_push;

  assign slot_idx = ENTRY_AW'(slot_q - SLOT_W'(1));

  // a popped entry number out of range falls back to entry zero
  always_comb begin
    if (!pop_r) begin
      new_idx = ENTRY_AW'(fresh_r);
    end else if ({1'b0, stk_q} >= (ENTRY_AW + 1)'(ENTRY_COUNT)) begin
      new_idx = '0;
    end else begin
      new_idx = stk_q;
    end
  end

  always_comb begin
    slot_we = cmd.clr_wr | cmd.del | cmd.place;
    slot_wa = pos_r;
    slot_wd = SLOT_TOMB;
    if (cmd.clr_wr) begin
      slot_wa = clr_r;
      slot_wd = SLOT_EMPTY;
    end else if (cmd.place) begin
      slot_wa = tgt_r;
      slot_wd = SLOT_W'(new_idx) + SLOT_W'(1);
    end
    val_we = cmd.upd_val | cmd.place;
    val_wa = cmd.place ? new_idx : idx_r;
  end

  assign stk_push = cmd.del && (depth_r < CNT_W'(ENTRY_COUNT));

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.slot_rd) slot_q <= slot_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.place) key_mem[new_idx] <= key_r;
    if (cmd.ent_rd) key_q <= key_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_r;
    if (cmd.ent_rd) val_q <= val_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (stk_push) stk_mem[ENTRY_AW'(depth_r)] <= idx_r;
    if (cmd.stk_rd) stk_q <= stk_mem[ENTRY_AW'(depth_r - CNT_W'(1))];
  end

  // request, probe, result and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r     <= in_req_type;
      key_r      <= in_key;
      val_r      <= in_value;
      pos_r      <= in_home_slot;
      probes_r   <= '0;
      have_tgt_r <= 1'b0;
      pop_r      <= 1'b0;
    end else begin
      if (cmd.advance) begin
        pos_r    <= pos_r + SLOT_AW'(1);
        probes_r <= probes_r + PROBE_W'(1);
      end
      if (cmd.note_tgt && !have_tgt_r) begin
        tgt_r      <= pos_r;
        have_tgt_r <= 1'b1;
      end
      if (cmd.stk_rd) pop_r <= 1'b1;
    end
    if (cmd.ent_rd) idx_r <= slot_idx;
    if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_val_r    <= cmd.res_val ? val_q : '0;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_val_r;
      out_live_r   <= kc_r;
    end
  end

  // counters and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      fresh_r     <= '0;
      kc_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_r <= clr_r + SLOT_AW'(1);
      if (cmd.stk_rd) begin
        depth_r <= depth_r - CNT_W'(1);
      end else if (stk_push) begin
        depth_r <= depth_r + CNT_W'(1);
      end
      if (cmd.place) begin
        kc_r <= kc_r + CNT_W'(1);
        if (!pop_r) fresh_r <= fresh_r + CNT_W'(1);
      end else if (cmd.del && kc_r != '0) begin
        kc_r <= kc_r - CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.clr_last       = (clr_r == SLOT_AW'(SLOT_COUNT - 1));
    stat.req_type       = type_r;
    stat.limit_full     = (fresh_r >= CNT_W'(ENTRY_COUNT)) ||
                          (kc_r >= CNT_W'(LIMIT_KEYS - 1));
    stat.probes_done    = (probes_r == PROBE_W'(SLOT_COUNT));
    stat.slot_empty     = (slot_q == SLOT_EMPTY);
    stat.slot_skip      = (slot_q > SLOT_W'(ENTRY_COUNT));
    stat.key_match      = (key_q == key_r);
    stat.have_tgt       = have_tgt_r;
    stat.stack_nonempty = (depth_r != '0);
    stat.out_busy       = out_valid_r && out_stall;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_live_count = out_live_r;

endmodule
`default_nettype wire

// ===== rtl/lphm_checker.sv =====
// Port-level checks for the linear probe hash map and their binding.
`default_nettype none
module lphm_checker
  import lphm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [STAT_W-1:0]     out_status,
  input wire logic [VALUE_BITS-1:0] out_value_out,
  input wire logic [CNT_W-1:0]      out_live_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_MISS ||
                   out_status == ST_FULL))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value_out == '0)
    else $error("failed request returned a value");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= CNT_W'(LIMIT_KEYS - 1))
    else $error("live count above load limit");

endmodule

bind linear_probe_hash_map_unit lphm_checker u_lphm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_value_out  (out_value_out),
  .out_live_count (out_live_count)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the linear probe hash map: directed and random requests against a predictor.
`default_nettype none
module tb;
  import lphm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TYPE_W-1:0] REQ_BAD = 2'd3;
  localparam int POOL_N = 40;

  typedef struct {
    logic [TYPE_W-1:0]     kind;
    logic [KEY_BITS-1:0]   key;
    logic [SLOT_AW-1:0]    home;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct {
    logic [STAT_W-1:0]     status;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TYPE_W-1:0] in_req_type = '0;
  logic [KEY_BITS-1:0] in_key = '0;
  logic [SLOT_AW-1:0] in_home_slot = '0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [VALUE_BITS-1:0] out_value_out;
  logic [CNT_W-1:0] out_live_count;

  linear_probe_hash_map_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_key(in_key), .in_home_slot(in_home_slot), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_value_out(out_value_out), .out_live_count(out_live_count)
  );

  always #10 clk = ~clk;

  // map shadow
  int unsigned slots [SLOT_COUNT];
  logic [KEY_BITS-1:0] ent_key [ENTRY_COUNT];
  logic [VALUE_BITS-1:0] ent_val [ENTRY_COUNT];
  int unsigned free_stack [ENTRY_COUNT];
  int unsigned free_depth = 0;
  int unsigned fresh_idx = 0;
  int unsigned live_keys = 0;

  req_t pending[$];
  res_t awaited[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit in_took = 1'b0;

  logic [KEY_BITS-1:0] pool_key [POOL_N];
  logic [SLOT_AW-1:0] pool_home [POOL_N];

  function automatic bit is_live(int unsigned s);
    return s != 0 && s != int'(SLOT_TOMB) && s <= ENTRY_COUNT;
  endfunction

  function automatic res_t map_apply(req_t r);
    res_t o;
    int unsigned pos;
    int unsigned tgt;
    int unsigned idx;
    bit have_tgt;
    bit hit;
    o.status = ST_MISS;
    o.value = '0;
    pos = r.home;
    have_tgt = 0;
    hit = 0;
    tgt = 0;
    if (r.kind == REQ_SET) begin
      if (fresh_idx >= ENTRY_COUNT || (live_keys + 1) * 4 >= SLOT_COUNT * 3) begin
        o.status = ST_FULL;
      end else begin
        for (int n = 0; n < SLOT_COUNT && !hit; n++) begin
          if (slots[pos] == 0) begin
            if (!have_tgt) begin
              tgt = pos;
              have_tgt = 1;
            end
            break;
          end
          if (!is_live(slots[pos])) begin
            if (!have_tgt) begin
              tgt = pos;
              have_tgt = 1;
            end
          end else if (ent_key[slots[pos]-1] == r.key) begin
            ent_val[slots[pos]-1] = r.value;
            hit = 1;
          end
          if (!hit) pos = (pos + 1) % SLOT_COUNT;
        end
        if (hit) begin
          o.status = ST_OK;
        end else if (!have_tgt) begin
          o.status = ST_FULL;
        end else begin
          if (free_depth > 0) begin
            free_depth--;
            idx = free_stack[free_depth % ENTRY_COUNT];
            if (idx >= ENTRY_COUNT) idx = 0;
          end else begin
            idx = fresh_idx++;
          end
          slots[tgt] = idx + 1;
          ent_key[idx] = r.key;
          ent_val[idx] = r.value;
          live_keys++;
          o.status = ST_OK;
        end
      end
    end else if (r.kind == REQ_GET || r.kind == REQ_DEL) begin
      for (int n = 0; n < SLOT_COUNT; n++) begin
        if (slots[pos] == 0) break;
        if (is_live(slots[pos]) && ent_key[slots[pos]-1] == r.key) begin
          hit = 1;
          break;
        end
        pos = (pos + 1) % SLOT_COUNT;
      end
      if (hit) begin
        idx = slots[pos] - 1;
        o.value = ent_val[idx];
        o.status = ST_OK;
        if (r.kind == REQ_DEL) begin
          if (free_depth < ENTRY_COUNT) free_stack[free_depth++] = idx;
          slots[pos] = int'(SLOT_TOMB);
          if (live_keys > 0) live_keys--;
        end
      end
    end
    o.count = live_keys[CNT_W-1:0];
    return o;
  endfunction

  function automatic void push_req(logic [TYPE_W-1:0] kind, logic [KEY_BITS-1:0] key,
                                   logic [SLOT_AW-1:0] home, logic [VALUE_BITS-1:0] value);
    req_t r;
    r.kind = kind;
    r.key = key;
    r.home = home;
    r.value = value;
    pending.push_back(r);
  endfunction

  function automatic void push_random(int cnt);
    int p;
    int pick;
    for (int i = 0; i < cnt; i++) begin
      pick = $urandom_range(99);
      p = $urandom_range(POOL_N - 1);
      if (pick < 40) push_req(REQ_SET, pool_key[p], pool_home[p], $urandom);
      else if (pick < 68) push_req(REQ_GET, pool_key[p], pool_home[p], $urandom);
      else if (pick < 90) push_req(REQ_DEL, pool_key[p], pool_home[p], $urandom);
      else if (pick < 94) push_req(REQ_BAD, pool_key[p], pool_home[p], $urandom);
      else push_req(TYPE_W'($urandom_range(3)), $urandom, SLOT_AW'($urandom), $urandom);
    end
  endfunction

  // accept an item and record what it should produce
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      req_t r;
      r.kind = in_req_type;
      r.key = in_key;
      r.home = in_home_slot;
      r.value = in_value;
      awaited.push_back(map_apply(r));
      in_took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || in_took) begin
        in_took = 1'b0;
        if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req_t r;
          r = pending.pop_front();
          in_req_type <= r.kind;
          in_key <= r.key;
          in_home_slot <= r.home;
          in_value <= r.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d value %h count %0d",
                                   out_status, out_value_out, out_live_count);
      end else begin
        res_t e;
        e = awaited.pop_front();
        if (out_status !== e.status || out_value_out !== e.value ||
            out_live_count !== e.count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp status %0d value %h count %0d, got %0d %h %0d",
                     e.status, e.value, e.count, out_status, out_value_out, out_live_count);
        end
      end
    end
  end

  task automatic drain();
    do @(posedge clk); while (pending.size() > 0 || in_valid || awaited.size() > 0);
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) slots[i] = 0;
    for (int i = 0; i < POOL_N; i++) begin
      pool_key[i] = $urandom;
      pool_home[i] = (i % 8 == 0) ? SLOT_AW'(1020 + $urandom_range(3)) :
                                    SLOT_AW'($urandom_range(120));
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // build a probe chain at slot 256, then free and reuse an entry
    for (int i = 0; i < 4; i++)
      push_req(REQ_SET, 32'hA000_0000 + KEY_BITS'(i), 10'd256, VALUE_BITS'(i));
    push_req(REQ_DEL, 32'hA000_0000, 10'd256, '0);
    push_req(REQ_GET, 32'hA000_0000, 10'd256, '0);            // miss past a tombstone
    push_req(REQ_GET, 32'hA000_0003, 10'd256, '0);            // hit past a tombstone
    push_req(REQ_SET, 32'h5555_AAAA, 10'd256, 32'hDEAD_BEEF); // reuse tombstone and entry
    push_req(REQ_GET, 32'h5555_AAAA, 10'd256, '0);
    drain();
    push_req(REQ_DEL, 32'h5555_AAAA, 10'd256, '0);
    for (int i = 1; i < 4; i++)
      push_req(REQ_DEL, 32'hA000_0000 + KEY_BITS'(i), 10'd256, '0);

    // extremes and wraparound
    push_req(REQ_SET, 32'h0, 10'd0, 32'h0);
    push_req(REQ_SET, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF);
    push_req(REQ_SET, 32'h5, 10'd1023, 32'h5);
    push_req(REQ_GET, 32'h5, 10'd1023, '0);
    push_req(REQ_GET, 32'hFFFF_FFFF, 10'd1023, '0);
    push_req(REQ_SET, 32'h0, 10'd0, 32'h7777_0000);
    push_req(REQ_GET, 32'h0, 10'd0, '0);
    push_req(REQ_DEL, 32'h0, 10'd0, '0);
    push_req(REQ_GET, 32'h0, 10'd0, '0);
    push_req(REQ_DEL, 32'h0, 10'd0, '0);
    push_req(REQ_SET, 32'h5, 10'd1023, 32'h6);                // match after a tombstone
    push_req(REQ_GET, 32'h5, 10'd1023, '0);
    push_req(REQ_BAD, 32'h5, 10'd1023, 32'hFFFF_FFFF);
    push_random(175);
    drain();

    idle_pct = 87;
    push_random(175);
    drain();
    idle_pct = 0;
    stall_pct = 87;
    push_random(175);
    drain();
    idle_pct = 34;
    stall_pct = 34;
    push_random(175);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lphm_pkg.sv
rtl/lphm_ctrl.sv
rtl/lphm_dp.sv
rtl/linear_probe_hash_map_unit.sv
rtl/lphm_checker.sv
test/tb.sv
